FILE: src/asoe_pkg.sv
// asoe_pkg: shared types and constants of the array set operation engine
// no dependencies; imported by asoe_front, asoe_back and the core top level
package asoe_pkg;

	// most items a single command may produce
	localparam int OUT_MAX     = 32;
	localparam int OUT_CNT_W   = $clog2(OUT_MAX + 1);
	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_APPEND    = 3'd1,
		OP_UNION     = 3'd2,
		OP_INTERSECT = 3'd3,
		OP_DIFF      = 3'd4,
		OP_SUBSET    = 3'd5,
		OP_DISJOINT  = 3'd6,
		OP_EQUAL     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACK    = 3'd0,
		KIND_ELEM   = 3'd1,
		KIND_EMPTY  = 3'd2,
		KIND_ANSWER = 3'd3,
		KIND_REJECT = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic               which_set;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] element;
		logic               answer;
		logic               either_empty;
		logic               last;
	} result_t;

	// decoded command as it sits in the queue
	typedef struct packed {
		op_t                op;
		logic               sel;
		logic               list_cmd;
		logic signed [31:0] value;
	} qent_t;

endpackage

FILE: src/array_set_operation_engine_core.sv
// array_set_operation_engine_core: top level of the array set operation engine
// depends on asoe_pkg, asoe_front and asoe_back
//
// Commands enter when start is high and busy is low; a two-entry command queue lets the
// host issue the next command while the previous one executes. Clear and append are
// handled in the idle state of the execution unit. Union, intersect, difference,
// subset, disjoint and equal walk the first operand list and then the second, one entry
// per cycle with every entry of both lists compared in parallel. Each result is shown
// for exactly one cycle with result_valid high and must be captured then; the receiver
// cannot stall. The final transaction of every command has last set, and an operation
// emits at most 32 results.
module array_set_operation_engine_core
	import asoe_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	logic  q_valid;
	qent_t q_entry;
	logic  pop;

	asoe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop)
	);

	asoe_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: src/asoe_front.sv
// asoe_front: accepts commands, decodes them and holds them in a short queue
// depends on asoe_pkg
module asoe_front
	import asoe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cmd_t  cmd,
	output logic  busy,
	output logic  q_valid,
	output qent_t q_entry,
	input  logic  pop
);

	qent_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	qent_t              dec;
	logic               push;
	logic               do_pop;

	always_comb begin
		dec.op       = op_t'(cmd.req_type);
		dec.sel      = cmd.which_set;
		dec.value    = cmd.value;
		unique case (cmd.req_type) inside
			OP_CLEAR, OP_APPEND: dec.list_cmd = 1'b1;
			default:             dec.list_cmd = 1'b0;
		endcase
	end

	assign busy    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign do_pop  = pop && q_valid;
	assign q_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/asoe_back.sv
// asoe_back: holds both lists and carries out queued commands, walking first and second list per set operation
// depends on asoe_pkg
module asoe_back
	import asoe_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  qent_t   q_entry,
	output logic    pop,
	output logic    result_valid,
	output result_t result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int HIT_W = $clog2(CAPACITY + 2);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	logic signed [31:0] list_a_q [CAPACITY];
	logic signed [31:0] list_b_q [CAPACITY];
	logic [CNT_W-1:0]   count_a_q;
	logic [CNT_W-1:0]   count_b_q;

	state_t             state_q;
	op_t                op_q;
	logic               sel_q;
	logic               emp_q;
	logic               phase_q;
	logic [CNT_W-1:0]   idx_q;
	logic [HIT_W-1:0]   hits_q;
	logic [OUT_CNT_W-1:0] ecnt_q;
	logic               pend_v_q;
	logic signed [31:0] pend_q;
	logic [CAPACITY-1:0] win_q;
	logic               result_valid_q;
	result_t            result_q;

	logic signed [31:0] fl [CAPACITY];
	logic signed [31:0] sl [CAPACITY];
	logic [CNT_W-1:0]   fn;
	logic [CNT_W-1:0]   sn;
	logic [CNT_W-1:0]   n_cur;
	logic signed [31:0] cand;
	logic               in_f, in_s, prior_f, prior_w;
	logic               walk_more;
	logic               keep, hit;
	logic               answer;
	logic               is_stream;
	logic               wr_a, wr_b;
	logic               res_v_d;
	result_t            res_d;

	// operand order follows the latched swap bit
	always_comb begin
		for (int j = 0; j < CAPACITY; j++) begin
			fl[j] = sel_q ? list_b_q[j] : list_a_q[j];
			sl[j] = sel_q ? list_a_q[j] : list_b_q[j];
		end
		fn = sel_q ? count_b_q : count_a_q;
		sn = sel_q ? count_a_q : count_b_q;
	end

	assign n_cur     = phase_q ? sn : fn;
	assign walk_more = (idx_q < n_cur);
	assign cand      = phase_q ? sl[idx_q[IDX_W-1:0]] : fl[idx_q[IDX_W-1:0]];

	// parallel membership compares against every live entry
	// an earlier second-list value only blocks a repeat while it sits among
	// the first CAPACITY distinct union values
	always_comb begin
		in_f    = 1'b0;
		in_s    = 1'b0;
		prior_f = 1'b0;
		prior_w = 1'b0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (fl[j] == cand && CNT_W'(j) < fn) in_f = 1'b1;
			if (sl[j] == cand && CNT_W'(j) < sn) in_s = 1'b1;
			if (fl[j] == cand && CNT_W'(j) < idx_q) prior_f = 1'b1;
			if (sl[j] == cand && CNT_W'(j) < idx_q && win_q[j]) prior_w = 1'b1;
		end
	end

	always_comb begin
		keep      = 1'b0;
		hit       = 1'b0;
		is_stream = 1'b0;
		answer    = 1'b0;
		unique case (op_q)
			OP_UNION: begin
				keep      = phase_q ? (!in_f && !prior_w) : !prior_f;
				is_stream = 1'b1;
			end
			OP_INTERSECT: begin
				keep      = phase_q && in_f;
				is_stream = 1'b1;
			end
			OP_DIFF: begin
				keep      = !phase_q && !in_s;
				is_stream = 1'b1;
			end
			OP_SUBSET: begin
				hit    = !phase_q && in_s;
				answer = (hits_q == HIT_W'(fn)) && (fn <= sn);
			end
			OP_DISJOINT: begin
				hit    = phase_q && in_f;
				answer = (hits_q == '0);
			end
			OP_EQUAL: begin
				hit    = phase_q && in_f;
				answer = (hits_q == HIT_W'(fn) + 1'b1);
			end
			default: ;
		endcase
	end

	assign pop  = (state_q == ST_IDLE) && q_valid;
	assign wr_a = pop && (q_entry.op == OP_APPEND) && !q_entry.sel
		&& (count_a_q < CNT_W'(CAPACITY));
	assign wr_b = pop && (q_entry.op == OP_APPEND) && q_entry.sel
		&& (count_b_q < CNT_W'(CAPACITY));

	// next result transaction
	always_comb begin
		res_v_d = 1'b0;
		res_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && q_entry.list_cmd) begin
					res_v_d    = 1'b1;
					res_d.last = 1'b1;
					res_d.kind = ((q_entry.op == OP_CLEAR) || wr_a || wr_b)
						? KIND_ACK : KIND_REJECT;
				end
			end
			ST_WALK: begin
				if (walk_more) begin
					// hold one element back so the final one can carry last
					if (keep && (ecnt_q < OUT_CNT_W'(OUT_MAX)) && pend_v_q) begin
						res_v_d            = 1'b1;
						res_d.kind         = KIND_ELEM;
						res_d.element      = pend_q;
						res_d.either_empty = emp_q;
					end
				end else if (phase_q) begin
					res_v_d            = 1'b1;
					res_d.last         = 1'b1;
					res_d.either_empty = emp_q;
					if (!is_stream) begin
						res_d.kind   = KIND_ANSWER;
						res_d.answer = answer;
					end else if (pend_v_q) begin
						res_d.kind    = KIND_ELEM;
						res_d.element = pend_q;
					end else begin
						res_d.kind = KIND_EMPTY;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			list_a_q[count_a_q[IDX_W-1:0]] <= q_entry.value;
		end
		if (wr_b) begin
			list_b_q[count_b_q[IDX_W-1:0]] <= q_entry.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_a_q      <= '0;
			count_b_q      <= '0;
			op_q           <= OP_CLEAR;
			sel_q          <= 1'b0;
			emp_q          <= 1'b0;
			phase_q        <= 1'b0;
			idx_q          <= '0;
			hits_q         <= '0;
			ecnt_q         <= '0;
			pend_v_q       <= 1'b0;
			pend_q         <= '0;
			win_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= res_v_d;
			result_q       <= res_d;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q  <= q_entry.op;
						sel_q <= q_entry.sel;
						emp_q <= (count_a_q == '0) || (count_b_q == '0);
						if (q_entry.list_cmd) begin
							if (q_entry.op == OP_CLEAR) begin
								if (q_entry.sel) count_b_q <= '0;
								else count_a_q <= '0;
							end else if (wr_a) begin
								count_a_q <= count_a_q + 1'b1;
							end else if (wr_b) begin
								count_b_q <= count_b_q + 1'b1;
							end
						end else begin
							state_q  <= ST_WALK;
							phase_q  <= 1'b0;
							idx_q    <= '0;
							ecnt_q   <= '0;
							pend_v_q <= 1'b0;
							// equal starts with one credit when the counts match
							hits_q   <= HIT_W'((q_entry.op == OP_EQUAL) && (count_a_q == count_b_q));
						end
					end
				end
				ST_WALK: begin
					if (walk_more) begin
						idx_q  <= idx_q + 1'b1;
						hits_q <= hits_q + HIT_W'(hit);
						if (phase_q) begin
							win_q[idx_q[IDX_W-1:0]] <= keep
								&& (ecnt_q < OUT_CNT_W'(CAPACITY));
						end
						if (keep && (ecnt_q < OUT_CNT_W'(OUT_MAX))) begin
							pend_q   <= cand;
							pend_v_q <= 1'b1;
							ecnt_q   <= ecnt_q + 1'b1;
						end
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						idx_q   <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: test/array_set_operation_engine_core_tb.sv
// array_set_operation_engine_core_tb: self-checking testbench for the set operation engine
// depends on asoe_pkg and array_set_operation_engine_core; a queue-fed driver and a
// clocked monitor compare every result against a behavioral model of both lists
`timescale 1ns / 100ps

module array_set_operation_engine_core_tb;
	import asoe_pkg::*;

	localparam int CAP            = 16;
	localparam int RANDOM_CMDS    = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	array_set_operation_engine_core #(
		.CAPACITY(CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model state: index 0 is list A, index 1 is list B
	logic [31:0] lists [2][CAP];
	int          list_len [2] = '{0, 0};

	cmd_t    cmds_pending [$];
	result_t results_due [$];

	logic cmd_taken = 1'b0;
	int   idle_left = 0;
	int   burst_left = 0;
	int   quiet_cycles = 0;
	int   error_count = 0;
	int   cmds_accepted = 0;
	int   results_checked = 0;
	int   elem_count = 0;
	int   answer_count = 0;
	int   empty_count = 0;
	int   reject_count = 0;

	function automatic result_t make_result(kind_t k, logic [31:0] e, logic a, logic emp);
		result_t r;
		r.kind         = k;
		r.element      = e;
		r.answer       = a;
		r.either_empty = emp;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic bit list_holds(int idx, logic [31:0] v);
		for (int i = 0; i < list_len[idx]; i++)
			if (lists[idx][i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// apply one command to the model lists and queue the results it causes
	task automatic compute_set_results(cmd_t c);
		op_t         op;
		int          f, s, hits, t;
		bit          dup;
		logic        emp;
		logic [31:0] v;
		logic [31:0] seen [$];
		result_t     batch [$];
		result_t     r;
		op   = op_t'(c.req_type);
		f    = c.which_set ? 1 : 0;
		s    = 1 - f;
		t    = f;
		hits = 0;
		emp  = (list_len[0] == 0 || list_len[1] == 0);
		case (op)
			OP_CLEAR: begin
				list_len[t] = 0;
				batch.push_back(make_result(KIND_ACK, '0, 1'b0, 1'b0));
			end
			OP_APPEND: begin
				if (list_len[t] >= CAP) begin
					batch.push_back(make_result(KIND_REJECT, '0, 1'b0, 1'b0));
				end else begin
					lists[t][list_len[t]] = c.value;
					list_len[t] = list_len[t] + 1;
					batch.push_back(make_result(KIND_ACK, '0, 1'b0, 1'b0));
				end
			end
			OP_UNION: begin
				for (int pass = 0; pass < 2; pass++) begin
					t = pass ? s : f;
					for (int i = 0; i < list_len[t]; i++) begin
						v = lists[t][i];
						dup = 1'b0;
						// only the first CAP distinct values block a repeat
						foreach (seen[j])
							if (j < CAP && seen[j] == v)
								dup = 1'b1;
						if (!dup) begin
							seen.push_back(v);
							batch.push_back(make_result(KIND_ELEM, v, 1'b0, emp));
						end
					end
				end
			end
			OP_INTERSECT: begin
				for (int i = 0; i < list_len[s]; i++)
					if (list_holds(f, lists[s][i]))
						batch.push_back(make_result(KIND_ELEM, lists[s][i], 1'b0, emp));
			end
			OP_DIFF: begin
				for (int i = 0; i < list_len[f]; i++)
					if (!list_holds(s, lists[f][i]))
						batch.push_back(make_result(KIND_ELEM, lists[f][i], 1'b0, emp));
			end
			OP_SUBSET: begin
				for (int i = 0; i < list_len[f]; i++)
					if (list_holds(s, lists[f][i]))
						hits++;
				batch.push_back(make_result(KIND_ANSWER, '0,
					(hits == list_len[f] && list_len[f] <= list_len[s]), emp));
			end
			OP_DISJOINT: begin
				for (int i = 0; i < list_len[s]; i++)
					if (list_holds(f, lists[s][i]))
						hits++;
				batch.push_back(make_result(KIND_ANSWER, '0, (hits == 0), emp));
			end
			default: begin
				// equal counts duplicates, plus one when the lengths match
				hits = (list_len[f] == list_len[s]) ? 1 : 0;
				for (int i = 0; i < list_len[s]; i++)
					if (list_holds(f, lists[s][i]))
						hits++;
				batch.push_back(make_result(KIND_ANSWER, '0, (hits == list_len[f] + 1), emp));
			end
		endcase
		if (batch.size() == 0)
			batch.push_back(make_result(KIND_EMPTY, '0, 1'b0, emp));
		while (batch.size() > OUT_MAX)
			void'(batch.pop_back());
		r = batch.pop_back();
		r.last = 1'b1;
		batch.push_back(r);
		foreach (batch[i])
			results_due.push_back(batch[i]);
	endtask

	task automatic check_result(result_t got);
		result_t want;
		results_checked++;
		case (got.kind)
			KIND_ELEM:   elem_count++;
			KIND_ANSWER: answer_count++;
			KIND_EMPTY:  empty_count++;
			KIND_REJECT: reject_count++;
			default: ;
		endcase
		if (results_due.size() == 0) begin
			$error("result with nothing expected: kind %0d element %0h", got.kind, got.element);
			error_count++;
		end else begin
			want = results_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				error_count++;
			end
			if (got.element !== want.element) begin
				$error("element: expected %0h, got %0h", want.element, got.element);
				error_count++;
			end
			if (got.answer !== want.answer) begin
				$error("answer: expected %0b, got %0b", want.answer, got.answer);
				error_count++;
			end
			if (got.either_empty !== want.either_empty) begin
				$error("either_empty: expected %0b, got %0b", want.either_empty,
					got.either_empty);
				error_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				error_count++;
			end
		end
	endtask

	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left = burst_left - 1;
			return 0;
		end
		// now and then a run of back-to-back transactions
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(4, 12);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// driver: one command per transaction, held until accepted
	always @(negedge clk) begin
		if (arst_n && (!start || cmd_taken)) begin
			if (idle_left > 0) begin
				idle_left = idle_left - 1;
				start <= 1'b0;
			end else if (cmds_pending.size() != 0) begin
				cmd <= cmds_pending.pop_front();
				start <= 1'b1;
				idle_left = draw_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results first, so older commands drain before new expectations land
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= start && !busy;
			if (result_valid)
				check_result(result);
			if (start && !busy) begin
				compute_set_results(cmd);
				cmds_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic queue_cmd(op_t op, logic sel, logic [31:0] v);
		cmd_t c;
		c.req_type  = op;
		c.which_set = sel;
		c.value     = v;
		cmds_pending.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		// mostly a small pool so the lists overlap
		if (r <= 5)
			return $urandom_range(0, 7);
		if (r == 6) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 7) == 0)
			return CAP + $urandom_range(0, 2);
		return $urandom_range(0, 5);
	endfunction

	initial begin
		int na, nb;
		// both lists empty: every operation
		queue_cmd(OP_UNION, 1'b0, 32'hffff_ffff);
		queue_cmd(OP_INTERSECT, 1'b1, '0);
		queue_cmd(OP_DIFF, 1'b0, '0);
		queue_cmd(OP_SUBSET, 1'b0, '0);
		queue_cmd(OP_DISJOINT, 1'b1, '0);
		queue_cmd(OP_EQUAL, 1'b0, '0);
		queue_cmd(OP_CLEAR, 1'b0, '0);
		// A with extremes and a duplicate, B still empty
		queue_cmd(OP_APPEND, 1'b0, 32'h8000_0000);
		queue_cmd(OP_APPEND, 1'b0, 32'h7fff_ffff);
		queue_cmd(OP_APPEND, 1'b0, 32'h8000_0000);
		queue_cmd(OP_UNION, 1'b0, '0);
		queue_cmd(OP_APPEND, 1'b1, 32'hffff_ffff);
		queue_cmd(OP_APPEND, 1'b1, 32'h7fff_ffff);
		queue_cmd(OP_APPEND, 1'b1, 32'h0000_0000);
		queue_cmd(OP_APPEND, 1'b1, 32'h7fff_ffff);
		queue_cmd(OP_UNION, 1'b1, '0);
		queue_cmd(OP_INTERSECT, 1'b0, '0);
		queue_cmd(OP_DIFF, 1'b1, '0);
		queue_cmd(OP_SUBSET, 1'b0, '0);
		queue_cmd(OP_DISJOINT, 1'b1, '0);
		queue_cmd(OP_EQUAL, 1'b0, '0);
		queue_cmd(OP_CLEAR, 1'b1, '0);
		queue_cmd(OP_EQUAL, 1'b1, '0);
		queue_cmd(OP_DIFF, 1'b0, '0);

		// fill A to capacity and one more to see the rejection
		queue_cmd(OP_CLEAR, 1'b0, $urandom);
		repeat (CAP + 1)
			queue_cmd(OP_APPEND, 1'b0, pick_value());
		queue_cmd(OP_UNION, 1'b0, $urandom);
		queue_cmd(OP_EQUAL, 1'b1, $urandom);
		while (cmds_pending.size() < RANDOM_CMDS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					if ($urandom_range(0, 2) != 0)
						queue_cmd(OP_CLEAR, 1'b0, $urandom);
					if ($urandom_range(0, 2) != 0)
						queue_cmd(OP_CLEAR, 1'b1, $urandom);
					na = pick_len();
					nb = pick_len();
					while (na + nb > 0) begin
						if (nb == 0 || (na > 0 && $urandom_range(0, 1))) begin
							queue_cmd(OP_APPEND, 1'b0, pick_value());
							na--;
						end else begin
							queue_cmd(OP_APPEND, 1'b1, pick_value());
							nb--;
						end
					end
					repeat ($urandom_range(1, 4))
						queue_cmd(op_t'($urandom_range(OP_UNION, OP_EQUAL)),
							1'($urandom_range(0, 1)), $urandom);
				end
				6, 7: begin
					repeat ($urandom_range(1, 3))
						queue_cmd(op_t'($urandom_range(OP_UNION, OP_EQUAL)),
							1'($urandom_range(0, 1)), $urandom);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						queue_cmd(op_t'($urandom_range(OP_CLEAR, OP_EQUAL)),
							1'($urandom_range(0, 1)), $urandom);
				end
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmds_pending.size() != 0 || start)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		// catch stray results after the last expected one
		repeat (2 * CAP + 8) @(posedge clk);

		$display("%0d commands accepted, %0d results checked", cmds_accepted, results_checked);
		$display("elements %0d, answers %0d, empty sets %0d, rejected appends %0d",
			elem_count, answer_count, empty_count, reject_count);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
